FILE: rtl/c8ic_pkg.sv
// ----------------------------------------------------------------------------
// c8ic_pkg
// Shared constants, opcode codes, command and status types for the
// instruction core controller and datapath.
// ----------------------------------------------------------------------------
package c8ic_pkg;

	// memory geometry
	localparam int MEM_DEPTH = 4096;
	localparam int MEM_AW    = 12;

	// default configuration
	localparam int DEF_PROGRAM_START = 512;
	localparam int DEF_STACK_DEPTH   = 16;
	localparam int DEF_TICK_MS       = 16;
	localparam int DEF_FONT_BASE     = 0;
	localparam int DEF_SCREEN_WIDTH  = 64;
	localparam int DEF_SCREEN_HEIGHT = 32;

	localparam int GLYPH_BYTES = 5;

	// item kinds
	localparam logic [2:0] KIND_LOAD = 3'd0;
	localparam logic [2:0] KIND_EXEC = 3'd1;
	localparam logic [2:0] KIND_KEY  = 3'd2;
	localparam logic [2:0] KIND_TIME = 3'd3;
	localparam logic [2:0] KIND_ROW  = 3'd4;

	// opcode groups (top nibble)
	localparam logic [3:0] NIB_SYS  = 4'h0;
	localparam logic [3:0] NIB_JP   = 4'h1;
	localparam logic [3:0] NIB_CALL = 4'h2;
	localparam logic [3:0] NIB_SE   = 4'h3;
	localparam logic [3:0] NIB_SNE  = 4'h4;
	localparam logic [3:0] NIB_SER  = 4'h5;
	localparam logic [3:0] NIB_LD   = 4'h6;
	localparam logic [3:0] NIB_ADD  = 4'h7;
	localparam logic [3:0] NIB_ALU  = 4'h8;
	localparam logic [3:0] NIB_SNER = 4'h9;
	localparam logic [3:0] NIB_LDI  = 4'hA;
	localparam logic [3:0] NIB_JPV  = 4'hB;
	localparam logic [3:0] NIB_RND  = 4'hC;
	localparam logic [3:0] NIB_DRW  = 4'hD;
	localparam logic [3:0] NIB_KEY  = 4'hE;
	localparam logic [3:0] NIB_MISC = 4'hF;

	localparam logic [15:0] OP_CLS = 16'h00E0;
	localparam logic [15:0] OP_RET = 16'h00EE;

	// alu selects (low nibble of 8xyn)
	localparam logic [3:0] ALU_MOV  = 4'h0;
	localparam logic [3:0] ALU_OR   = 4'h1;
	localparam logic [3:0] ALU_AND  = 4'h2;
	localparam logic [3:0] ALU_XOR  = 4'h3;
	localparam logic [3:0] ALU_ADD  = 4'h4;
	localparam logic [3:0] ALU_SUB  = 4'h5;
	localparam logic [3:0] ALU_SHR  = 4'h6;
	localparam logic [3:0] ALU_SUBN = 4'h7;
	localparam logic [3:0] ALU_SHL  = 4'hE;

	// low byte codes of Ex and Fx groups
	localparam logic [7:0] KK_SKP  = 8'h9E;
	localparam logic [7:0] KK_SKNP = 8'hA1;
	localparam logic [7:0] KK_GDT  = 8'h07;
	localparam logic [7:0] KK_WKEY = 8'h0A;
	localparam logic [7:0] KK_SDT  = 8'h15;
	localparam logic [7:0] KK_SST  = 8'h18;
	localparam logic [7:0] KK_ADDI = 8'h1E;
	localparam logic [7:0] KK_FONT = 8'h29;
	localparam logic [7:0] KK_BCD  = 8'h33;
	localparam logic [7:0] KK_STR  = 8'h55;
	localparam logic [7:0] KK_LDR  = 8'h65;

	typedef enum logic [4:0] {
		DP_NONE, DP_CLR, DP_CAPTURE, DP_LOAD, DP_KEY, DP_ELAPSE, DP_ROW,
		DP_FETCH_HI, DP_FETCH_LO, DP_FETCH_END, DP_RD_X, DP_RD_V0, DP_RD_Y,
		DP_EXEC, DP_CLS, DP_RET, DP_DIV_MUL, DP_DIV_WR,
		DP_DRW_INIT, DP_DRW_MOD, DP_DRW_RD, DP_DRW_XOR, DP_DRW_END,
		DP_BCD0, DP_BCD1, DP_BCD2, DP_ST, DP_LD_RD, DP_LD_WR, DP_OUT
	} dp_cmd_t;

	typedef struct packed {
		dp_cmd_t cmd;
	} dp_ctl_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] op;
		logic        clr_last;
		logic        mod_done;
		logic        cnt_eq_x;
		logic        cnt_eq_n;
	} dp_stat_t;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_KIND, S_FL, S_FW, S_RX, S_RY, S_EXEC, S_DIVW,
		S_DMOD, S_DRD, S_DXOR, S_BCD1, S_BCD2, S_ST, S_LDR, S_LDW, S_DONE
	} ctl_state_t;

endpackage

FILE: rtl/c8ic_ram.sv
// ----------------------------------------------------------------------------
// c8ic_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module c8ic_ram
	import c8ic_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = MEM_DEPTH,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/c8ic_ctrl.sv
// ----------------------------------------------------------------------------
// c8ic_ctrl
// Sequencer: steps each item through fetch, operand read and the multi
// cycle instruction loops, and owns the output beat handshake.
// ----------------------------------------------------------------------------
module c8ic_ctrl
	import c8ic_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_ctl_t  ctl
);

	ctl_state_t state_q, state_d;
	dp_cmd_t    cmd;
	logic       out_vld_q;
	logic [3:0] op_hi;
	logic [7:0] op_kk;

	assign op_hi = stat.op[15:12];
	assign op_kk = stat.op[7:0];

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and datapath command
	always_comb begin
		state_d = state_q;
		cmd     = DP_NONE;
		unique case (state_q)
			S_CLEAR: begin
				cmd = DP_CLR;
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd     = DP_CAPTURE;
					state_d = S_KIND;
				end
			end
			S_KIND: begin
				state_d = S_DONE;
				case (stat.kind)
					KIND_LOAD: cmd = DP_LOAD;
					KIND_KEY:  cmd = DP_KEY;
					KIND_TIME: cmd = DP_ELAPSE;
					KIND_ROW:  cmd = DP_ROW;
					KIND_EXEC: begin
						cmd     = DP_FETCH_HI;
						state_d = S_FL;
					end
					default: cmd = DP_NONE;
				endcase
			end
			S_FL: begin
				cmd     = DP_FETCH_LO;
				state_d = S_FW;
			end
			S_FW: begin
				cmd     = DP_FETCH_END;
				state_d = S_RX;
			end
			S_RX: begin
				cmd     = (op_hi == NIB_JPV) ? DP_RD_V0 : DP_RD_X;
				state_d = S_RY;
			end
			S_RY: begin
				cmd     = DP_RD_Y;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_DONE;
				if (stat.op == OP_CLS) begin
					cmd = DP_CLS;
				end else if (stat.op == OP_RET) begin
					cmd = DP_RET;
				end else if (op_hi == NIB_DRW) begin
					cmd     = DP_DRW_INIT;
					state_d = S_DMOD;
				end else if (op_hi == NIB_MISC && op_kk == KK_GDT) begin
					cmd     = DP_DIV_MUL;
					state_d = S_DIVW;
				end else if (op_hi == NIB_MISC && op_kk == KK_BCD) begin
					cmd     = DP_BCD0;
					state_d = S_BCD1;
				end else if (op_hi == NIB_MISC && op_kk == KK_STR) begin
					state_d = S_ST;
				end else if (op_hi == NIB_MISC && op_kk == KK_LDR) begin
					state_d = S_LDR;
				end else begin
					cmd = DP_EXEC;
				end
			end
			S_DIVW: begin
				cmd     = DP_DIV_WR;
				state_d = S_DONE;
			end
			S_DMOD: begin
				if (stat.mod_done) state_d = S_DRD;
				else cmd = DP_DRW_MOD;
			end
			S_DRD: begin
				if (stat.cnt_eq_n) begin
					cmd     = DP_DRW_END;
					state_d = S_DONE;
				end else begin
					cmd     = DP_DRW_RD;
					state_d = S_DXOR;
				end
			end
			S_DXOR: begin
				cmd     = DP_DRW_XOR;
				state_d = S_DRD;
			end
			S_BCD1: begin
				cmd     = DP_BCD1;
				state_d = S_BCD2;
			end
			S_BCD2: begin
				cmd     = DP_BCD2;
				state_d = S_DONE;
			end
			S_ST: begin
				cmd = DP_ST;
				if (stat.cnt_eq_x) state_d = S_DONE;
			end
			S_LDR: begin
				cmd     = DP_LD_RD;
				state_d = S_LDW;
			end
			S_LDW: begin
				cmd     = DP_LD_WR;
				state_d = stat.cnt_eq_x ? S_DONE : S_LDR;
			end
			S_DONE: begin
				if (!out_vld_q || out_ready) begin
					cmd     = DP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd == DP_OUT) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_vld_q;
	assign ctl.cmd   = cmd;

endmodule

FILE: rtl/c8ic_dpath.sv
// ----------------------------------------------------------------------------
// c8ic_dpath
// Machine state and execution units: RAM, register file, index, program
// counter, return stack, timers, keys, framebuffer and the result register.
// ----------------------------------------------------------------------------
module c8ic_dpath
	import c8ic_pkg::*;
#(
	parameter int PROGRAM_START = DEF_PROGRAM_START,
	parameter int STACK_DEPTH   = DEF_STACK_DEPTH,
	parameter int TICK_MS       = DEF_TICK_MS,
	parameter int FONT_BASE     = DEF_FONT_BASE,
	parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_ctl_t     ctl,
	output dp_stat_t    stat,
	input  logic [2:0]  kind,
	input  logic [11:0] address,
	input  logic [7:0]  data_byte,
	input  logic [3:0]  key_index,
	input  logic        key_down,
	input  logic [15:0] elapsed_ms,
	input  logic [7:0]  random_byte,
	input  logic [4:0]  row_select,
	output logic [15:0] opcode,
	output logic [11:0] pc,
	output logic [15:0] index_addr,
	output logic [7:0]  flag_value,
	output logic        waiting_key,
	output logic        sound_on,
	output logic        display_changed,
	output logic [63:0] row_bits
);

	localparam int SP_W   = $clog2(STACK_DEPTH);
	localparam int RW     = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
	localparam int DIV_SH = 24;
	localparam int RECIP  = ((1 << DIV_SH) + TICK_MS - 1) / TICK_MS;
	localparam int RC_W   = DIV_SH + 1;
	localparam logic [7:0] W8 = 8'(SCREEN_WIDTH);
	localparam logic [7:0] H8 = 8'(SCREEN_HEIGHT);
	localparam logic [RC_W-1:0] RECIP_V = RC_W'(RECIP);

	dp_cmd_t cmd;
	assign cmd = ctl.cmd;

	// captured item fields
	logic [2:0]  kind_q;
	logic [11:0] addr_q;
	logic [7:0]  data_q;
	logic [3:0]  keyi_q;
	logic        keyd_q;
	logic [15:0] elap_q;
	logic [7:0]  rnd_q;
	logic [4:0]  rsel_q;

	// machine state
	logic [11:0]            pc_q;
	logic [15:0]            idx_q;
	logic [7:0]             v_q [16];
	logic [SP_W-1:0]        sp_q;
	logic [STACK_DEPTH-1:0] stk_vld_q;
	logic [11:0]            dly_q;
	logic [11:0]            snd_q;
	logic [15:0]            key_q;
	logic [63:0]            fb_q [SCREEN_HEIGHT];
	logic [MEM_AW-1:0]      clr_q;

	// working registers
	logic [15:0]             op_q;
	logic [7:0]              a_q;
	logic [7:0]              b_q;
	logic [3:0]              cnt_q;
	logic [7:0]              xm_q;
	logic [7:0]              ym_q;
	logic                    hit_q;
	logic [12+RC_W-1:0]      prod_q;

	// per item report
	logic [15:0] rep_op_q;
	logic        rep_wait_q;
	logic        rep_disp_q;
	logic [63:0] rep_row_q;

	// result register
	logic [15:0] o_op_q;
	logic [11:0] o_pc_q;
	logic [15:0] o_idx_q;
	logic [7:0]  o_vf_q;
	logic        o_wait_q;
	logic        o_snd_q;
	logic        o_disp_q;
	logic [63:0] o_row_q;

	// opcode fields
	logic [3:0]  op_hi, op_x, op_y, op_n;
	logic [7:0]  op_kk;
	logic [11:0] op_nnn;
	assign op_hi  = op_q[15:12];
	assign op_x   = op_q[11:8];
	assign op_y   = op_q[7:4];
	assign op_n   = op_q[3:0];
	assign op_kk  = op_q[7:0];
	assign op_nnn = op_q[11:0];

	// main RAM port
	logic              mem_we;
	logic [MEM_AW-1:0] mem_waddr, mem_raddr, idx_cnt;
	logic [7:0]        mem_wdata, mem_rdata;

	// stack RAM port
	logic            stk_we;
	logic [SP_W-1:0] sp_inc, sp_dec;
	logic [11:0]     stk_rdata;

	// register file read port
	logic [3:0] rf_raddr;
	logic [7:0] rf_rd;

	// alu, digits, draw, keys
	logic [8:0]  sum9;
	logic [7:0]  alu_a, alu_b, alu_r;
	logic        alu_f, alu_wf, alu_wr;
	logic [7:0]  bcd_h, bcd_r, bcd_t, bcd_u;
	logic [15:0] bcd_m;
	logic [RW-1:0] fb_idx;
	logic [63:0] fb_rd, dmask;
	logic [7:0]  dcol;
	logic        key_dn, key_any;
	logic [3:0]  key_low;
	logic [11:0] pc_skip;

	assign idx_cnt = idx_q[MEM_AW-1:0] + MEM_AW'(cnt_q);
	assign pc_skip = pc_q + 12'd2;
	assign sp_inc  = (sp_q == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_q + 1'b1;
	assign sp_dec  = (sp_q == '0) ? SP_W'(STACK_DEPTH - 1) : sp_q - 1'b1;

	// main RAM address and write mux
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_cnt;
		mem_wdata = rf_rd;
		mem_raddr = pc_q;
		case (cmd)
			DP_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			DP_LOAD: begin
				mem_we    = 1'b1;
				mem_waddr = addr_q;
				mem_wdata = data_q;
			end
			DP_BCD0: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q[MEM_AW-1:0];
				mem_wdata = bcd_h;
			end
			DP_BCD1: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q[MEM_AW-1:0] + MEM_AW'(1);
				mem_wdata = bcd_t;
			end
			DP_BCD2: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q[MEM_AW-1:0] + MEM_AW'(2);
				mem_wdata = bcd_u;
			end
			DP_ST:       mem_we    = 1'b1;
			DP_FETCH_LO: mem_raddr = pc_q + 12'd1;
			DP_DRW_RD,
			DP_LD_RD:    mem_raddr = idx_cnt;
			default:     mem_we    = 1'b0;
		endcase
	end

	c8ic_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// return stack: read address follows the pointer
	assign stk_we = (cmd == DP_EXEC) && (op_hi == NIB_CALL);

	c8ic_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (sp_inc),
		.wdata (pc_q),
		.raddr (sp_q),
		.rdata (stk_rdata)
	);

	// register file read select
	always_comb begin
		case (cmd)
			DP_RD_V0: rf_raddr = 4'h0;
			DP_RD_Y:  rf_raddr = op_y;
			DP_ST:    rf_raddr = cnt_q;
			default:  rf_raddr = op_x;
		endcase
	end
	assign rf_rd = v_q[rf_raddr];

	// 8xyn alu: flag from the original operands, sub and shift results from current values
	always_comb begin
		sum9   = {1'b0, a_q} + {1'b0, b_q};
		alu_f  = 1'b0;
		alu_wf = 1'b0;
		alu_wr = 1'b1;
		case (op_n)
			ALU_SUB:  alu_f = (a_q > b_q);
			ALU_SHR:  alu_f = a_q[0];
			ALU_SUBN: alu_f = (b_q > a_q);
			ALU_SHL:  alu_f = a_q[7];
			default:  alu_f = sum9[8];
		endcase
		alu_a = (op_x == 4'hF) ? {7'b0, alu_f} : a_q;
		alu_b = (op_y == 4'hF) ? {7'b0, alu_f} : b_q;
		case (op_n)
			ALU_MOV: alu_r = b_q;
			ALU_OR:  alu_r = a_q | b_q;
			ALU_AND: alu_r = a_q & b_q;
			ALU_XOR: alu_r = a_q ^ b_q;
			ALU_ADD: begin
				alu_r  = sum9[7:0];
				alu_wf = 1'b1;
			end
			ALU_SUB: begin
				alu_r  = alu_a - alu_b;
				alu_wf = 1'b1;
			end
			ALU_SHR: begin
				alu_r  = alu_a >> 1;
				alu_wf = 1'b1;
			end
			ALU_SUBN: begin
				alu_r  = alu_b - alu_a;
				alu_wf = 1'b1;
			end
			ALU_SHL: begin
				alu_r  = alu_a << 1;
				alu_wf = 1'b1;
			end
			default: begin
				alu_r  = a_q;
				alu_wr = 1'b0;
			end
		endcase
	end

	// decimal digits of Vx; tens by reciprocal multiply (exact below 100)
	always_comb begin
		if (a_q >= 8'd200) begin
			bcd_h = 8'd2;
			bcd_r = a_q - 8'd200;
		end else if (a_q >= 8'd100) begin
			bcd_h = 8'd1;
			bcd_r = a_q - 8'd100;
		end else begin
			bcd_h = 8'd0;
			bcd_r = a_q;
		end
		bcd_m = {8'b0, bcd_r} * 16'd205;
		bcd_t = {3'b0, bcd_m[15:11]};
		bcd_u = bcd_r - {bcd_t[4:0], 3'b0} - {bcd_t[6:0], 1'b0};
	end

	// framebuffer row access and sprite mask with column wrap
	assign fb_idx = (cmd == DP_ROW) ? rsel_q[RW-1:0] : ym_q[RW-1:0];
	assign fb_rd  = fb_q[fb_idx];

	always_comb begin
		dmask = '0;
		dcol  = '0;
		for (int c = 0; c < 8; c++) begin
			dcol = xm_q + 8'(c);
			if (dcol >= W8) dcol = dcol - W8;
			if (mem_rdata[7-c]) dmask = dmask | (64'h8000_0000_0000_0000 >> dcol[5:0]);
		end
	end

	// key lookups
	assign key_dn = (a_q < 8'd16) && key_q[a_q[3:0]];
	assign key_any = |key_q;
	always_comb begin
		key_low = '0;
		for (int k = 15; k >= 0; k--) begin
			if (key_q[k]) key_low = 4'(k);
		end
	end

	// state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q       <= MEM_AW'(PROGRAM_START);
			idx_q      <= '0;
			for (int i = 0; i < 16; i++) v_q[i] <= '0;
			sp_q       <= '0;
			stk_vld_q  <= '0;
			dly_q      <= '0;
			snd_q      <= '0;
			key_q      <= '0;
			fb_q       <= '{default: '0};
			clr_q      <= '0;
			cnt_q      <= '0;
			rep_op_q   <= '0;
			rep_wait_q <= 1'b0;
			rep_disp_q <= 1'b0;
			rep_row_q  <= '0;
			kind_q     <= '0;
		end else begin
			case (cmd)
				DP_CLR: clr_q <= clr_q + 1'b1;
				DP_CAPTURE: begin
					kind_q     <= kind;
					rep_op_q   <= '0;
					rep_wait_q <= 1'b0;
					rep_disp_q <= 1'b0;
					rep_row_q  <= '0;
				end
				DP_KEY: key_q[keyi_q] <= keyd_q;
				DP_ELAPSE: begin
					dly_q <= ({4'b0, dly_q} > elap_q) ? dly_q - elap_q[11:0] : '0;
					snd_q <= ({4'b0, snd_q} > elap_q) ? snd_q - elap_q[11:0] : '0;
				end
				DP_ROW: begin
					if (32'(rsel_q) < SCREEN_HEIGHT) rep_row_q <= fb_rd;
				end
				DP_FETCH_END: begin
					rep_op_q <= {op_q[15:8], mem_rdata};
					pc_q     <= pc_skip;
				end
				DP_RD_Y: cnt_q <= '0;
				DP_CLS: begin
					fb_q       <= '{default: '0};
					rep_disp_q <= 1'b1;
				end
				DP_RET: begin
					pc_q <= stk_vld_q[sp_q] ? stk_rdata : '0;
					sp_q <= sp_dec;
				end
				DP_DIV_WR: v_q[op_x] <= prod_q[DIV_SH+7:DIV_SH];
				DP_DRW_INIT: begin
					cnt_q      <= '0;
					rep_disp_q <= 1'b1;
				end
				DP_DRW_XOR: begin
					fb_q[fb_idx] <= fb_rd ^ dmask;
					cnt_q        <= cnt_q + 1'b1;
				end
				DP_DRW_END: v_q[15] <= {7'b0, hit_q};
				DP_ST: cnt_q <= cnt_q + 1'b1;
				DP_LD_WR: begin
					v_q[cnt_q] <= mem_rdata;
					cnt_q      <= cnt_q + 1'b1;
				end
				DP_EXEC: begin
					case (op_hi)
						NIB_JP: pc_q <= op_nnn;
						NIB_CALL: begin
							sp_q              <= sp_inc;
							stk_vld_q[sp_inc] <= 1'b1;
							pc_q              <= op_nnn;
						end
						NIB_SE:   if (a_q == op_kk) pc_q <= pc_skip;
						NIB_SNE:  if (a_q != op_kk) pc_q <= pc_skip;
						NIB_SER:  if (op_n == 4'h0 && a_q == b_q) pc_q <= pc_skip;
						NIB_SNER: if (op_n == 4'h0 && a_q != b_q) pc_q <= pc_skip;
						NIB_LD:   v_q[op_x] <= op_kk;
						NIB_ADD:  v_q[op_x] <= a_q + op_kk;
						NIB_ALU: begin
							if (alu_wf) v_q[15] <= {7'b0, alu_f};
							if (alu_wr) v_q[op_x] <= alu_r;
						end
						NIB_LDI: idx_q <= {4'b0, op_nnn};
						NIB_JPV: pc_q <= op_nnn + {4'b0, a_q};
						NIB_RND: v_q[op_x] <= rnd_q & op_kk;
						NIB_KEY: begin
							if (op_kk == KK_SKP && key_dn) pc_q <= pc_skip;
							if (op_kk == KK_SKNP && !key_dn) pc_q <= pc_skip;
						end
						NIB_MISC: begin
							case (op_kk)
								KK_WKEY: begin
									if (key_any) begin
										v_q[op_x] <= {4'b0, key_low};
									end else begin
										pc_q       <= pc_q - 12'd2;
										rep_wait_q <= 1'b1;
									end
								end
								KK_SDT:  dly_q <= 12'(32'(a_q) * TICK_MS);
								KK_SST:  snd_q <= 12'(32'(a_q) * TICK_MS);
								KK_ADDI: idx_q <= idx_q + {8'b0, a_q};
								KK_FONT: idx_q <= 16'(FONT_BASE + 32'(a_q) * GLYPH_BYTES);
								default: idx_q <= idx_q;
							endcase
						end
						default: pc_q <= pc_q;
					endcase
				end
				default: clr_q <= clr_q;
			endcase
		end
	end

	// payload and working registers
	always_ff @(posedge clk) begin
		case (cmd)
			DP_CAPTURE: begin
				addr_q <= address;
				data_q <= data_byte;
				keyi_q <= key_index;
				keyd_q <= key_down;
				elap_q <= elapsed_ms;
				rnd_q  <= random_byte;
				rsel_q <= row_select;
			end
			DP_FETCH_LO:  op_q[15:8] <= mem_rdata;
			DP_FETCH_END: op_q[7:0]  <= mem_rdata;
			DP_RD_X,
			DP_RD_V0:     a_q <= rf_rd;
			DP_RD_Y:      b_q <= rf_rd;
			DP_DIV_MUL:   prod_q <= {{RC_W{1'b0}}, dly_q} * {12'b0, RECIP_V};
			DP_DRW_INIT: begin
				xm_q  <= a_q;
				ym_q  <= b_q;
				hit_q <= 1'b0;
			end
			DP_DRW_MOD: begin
				if (xm_q >= W8) xm_q <= xm_q - W8;
				if (ym_q >= H8) ym_q <= ym_q - H8;
			end
			DP_DRW_XOR: begin
				hit_q <= hit_q | (|(fb_rd & dmask));
				ym_q  <= (ym_q + 8'd1 == H8) ? 8'd0 : ym_q + 8'd1;
			end
			DP_OUT: begin
				o_op_q   <= rep_op_q;
				o_pc_q   <= pc_q;
				o_idx_q  <= idx_q;
				o_vf_q   <= v_q[15];
				o_wait_q <= rep_wait_q;
				o_snd_q  <= (snd_q != '0);
				o_disp_q <= rep_disp_q;
				o_row_q  <= rep_row_q;
			end
			default: hit_q <= hit_q;
		endcase
	end

	// status to the sequencer
	assign stat.kind     = kind_q;
	assign stat.op       = op_q;
	assign stat.clr_last = (clr_q == '1);
	assign stat.mod_done = (xm_q < W8) && (ym_q < H8);
	assign stat.cnt_eq_x = (cnt_q == op_x);
	assign stat.cnt_eq_n = (cnt_q == op_n);

	assign opcode          = o_op_q;
	assign pc              = o_pc_q;
	assign index_addr      = o_idx_q;
	assign flag_value      = o_vf_q;
	assign waiting_key     = o_wait_q;
	assign sound_on        = o_snd_q;
	assign display_changed = o_disp_q;
	assign row_bits        = o_row_q;

endmodule

FILE: rtl/chip8_instruction_core_unit.sv
// ----------------------------------------------------------------------------
// chip8_instruction_core_unit
// Instruction core with 4 KB RAM, register file, stack, timers, keys and a
// XOR framebuffer; one result beat for every input beat.
// ----------------------------------------------------------------------------
// usage:
//   input beat (in_valid/in_ready) carries one item: load a RAM byte, execute
//   one instruction, set a key, let milliseconds pass, or read a screen row.
//   output beat (out_valid/out_ready) reports opcode, pc, index, VF, the
//   key-wait, sound and display flags, and the row pixels.
//   sequence: load, key, time and row items are captured, acted on and
//   put in the result register; an instruction fetches its two bytes,
//   reads Vx (or V0) and Vy, executes and writes the result. drawing wraps
//   the start, then reads and xors each sprite row; block store and load go
//   register by register, BCD writes three digits, timer read multiplies
//   then writes. one item at a time runs through the sequencer and the
//   single RAM port: a new item is taken once the last is in the result
//   register. after reset the RAM is swept to zero, with in_ready low.
//   a stalled receiver holds the result register; the next item is accepted
//   and processed, then waits for the register to free.
// ----------------------------------------------------------------------------
module chip8_instruction_core_unit
	import c8ic_pkg::*;
#(
	parameter int PROGRAM_START = DEF_PROGRAM_START,
	parameter int STACK_DEPTH   = DEF_STACK_DEPTH,
	parameter int TICK_MS       = DEF_TICK_MS,
	parameter int FONT_BASE     = DEF_FONT_BASE,
	parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  kind,
	input  logic [11:0] address,
	input  logic [7:0]  data_byte,
	input  logic [3:0]  key_index,
	input  logic        key_down,
	input  logic [15:0] elapsed_ms,
	input  logic [7:0]  random_byte,
	input  logic [4:0]  row_select,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] opcode,
	output logic [11:0] pc,
	output logic [15:0] index_addr,
	output logic [7:0]  flag_value,
	output logic        waiting_key,
	output logic        sound_on,
	output logic        display_changed,
	output logic [63:0] row_bits
);

	dp_ctl_t  ctl;
	dp_stat_t stat;

	// sequencer
	c8ic_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	// machine state and execution
	c8ic_dpath #(
		.PROGRAM_START (PROGRAM_START),
		.STACK_DEPTH   (STACK_DEPTH),
		.TICK_MS       (TICK_MS),
		.FONT_BASE     (FONT_BASE),
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.stat            (stat),
		.kind            (kind),
		.address         (address),
		.data_byte       (data_byte),
		.key_index       (key_index),
		.key_down        (key_down),
		.elapsed_ms      (elapsed_ms),
		.random_byte     (random_byte),
		.row_select      (row_select),
		.opcode          (opcode),
		.pc              (pc),
		.index_addr      (index_addr),
		.flag_value      (flag_value),
		.waiting_key     (waiting_key),
		.sound_on        (sound_on),
		.display_changed (display_changed),
		.row_bits        (row_bits)
	);

	// one item in flight: an accepted beat closes the input until done
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while an item is in flight");

	// key-wait flag only comes from the key-wait instruction
	a_wait_src: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && waiting_key) |->
		(opcode[15:12] == NIB_MISC && opcode[7:0] == KK_WKEY))
		else $error("waiting_key without key-wait opcode");

	// display flag only from clear or draw
	a_disp_src: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && display_changed) |->
		(opcode[15:12] == NIB_DRW || opcode == OP_CLS))
		else $error("display_changed without clear or draw");

endmodule

FILE: dv/chip8_core_checker.sv
// ----------------------------------------------------------------------------
// chip8_core_checker
// Watches both beat channels of the instruction core, keeps its own model
// of RAM, registers, stack, timers, keys and screen, and compares every
// result beat field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module chip8_core_checker
	import c8ic_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [2:0]  kind,
	input  logic [11:0] address,
	input  logic [7:0]  data_byte,
	input  logic [3:0]  key_index,
	input  logic        key_down,
	input  logic [15:0] elapsed_ms,
	input  logic [7:0]  random_byte,
	input  logic [4:0]  row_select,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [15:0] opcode,
	input  logic [11:0] pc,
	input  logic [15:0] index_addr,
	input  logic [7:0]  flag_value,
	input  logic        waiting_key,
	input  logic        sound_on,
	input  logic        display_changed,
	input  logic [63:0] row_bits,
	input  logic        end_of_run,
	output int          fail_count
);

	typedef struct {
		logic [15:0] opcode;
		logic [11:0] pc;
		logic [15:0] index_addr;
		logic [7:0]  flag_value;
		logic        waiting_key;
		logic        sound_on;
		logic        display_changed;
		logic [63:0] row_bits;
	} core_status_t;

	// model of the core state
	logic [7:0]  ram [MEM_DEPTH];
	logic [7:0]  vreg [16];
	logic [15:0] ireg;
	logic [11:0] prog_ctr;
	int          sp;
	logic [11:0] ret_stack [DEF_STACK_DEPTH];
	int          delay_left, sound_left;
	logic        key_held [16];
	logic [63:0] screen [DEF_SCREEN_HEIGHT];

	core_status_t status_q [$];
	int           mismatches;

	assign fail_count = mismatches + (end_of_run ? status_q.size() : 0);

	task automatic clear_model();
		for (int i = 0; i < MEM_DEPTH; i++) ram[i] = '0;
		for (int i = 0; i < 16; i++) begin
			vreg[i] = '0;
			key_held[i] = 1'b0;
		end
		for (int i = 0; i < DEF_STACK_DEPTH; i++) ret_stack[i] = '0;
		for (int i = 0; i < DEF_SCREEN_HEIGHT; i++) screen[i] = '0;
		ireg = '0;
		prog_ctr = 12'(DEF_PROGRAM_START);
		sp = 0;
		delay_left = 0;
		sound_left = 0;
	endtask

	// one instruction at the program counter, returns the fetched word
	task automatic run_instruction(input logic [7:0] rnd, output logic [15:0] op,
			output logic wkey, output logic disp);
		logic [3:0]  x, y, n;
		logic [7:0]  kk, px, py, spb;
		logic [11:0] nnn;
		logic [8:0]  sum;
		logic        hit, down;
		int          sx, sy, k;
		op = {ram[prog_ctr], ram[prog_ctr + 12'd1]};
		x = op[11:8];
		y = op[7:4];
		n = op[3:0];
		kk = op[7:0];
		nnn = op[11:0];
		wkey = 1'b0;
		disp = 1'b0;
		prog_ctr = prog_ctr + 12'd2;
		case (op[15:12])
			NIB_SYS: begin
				if (op == OP_CLS) begin
					for (int i = 0; i < DEF_SCREEN_HEIGHT; i++) screen[i] = '0;
					disp = 1'b1;
				end else if (op == OP_RET) begin
					prog_ctr = ret_stack[sp];
					sp = (sp + DEF_STACK_DEPTH - 1) % DEF_STACK_DEPTH;
				end
			end
			NIB_JP: prog_ctr = nnn;
			NIB_CALL: begin
				sp = (sp + 1) % DEF_STACK_DEPTH;
				ret_stack[sp] = prog_ctr;
				prog_ctr = nnn;
			end
			NIB_SE:   if (vreg[x] == kk) prog_ctr = prog_ctr + 12'd2;
			NIB_SNE:  if (vreg[x] != kk) prog_ctr = prog_ctr + 12'd2;
			NIB_SER:  if (n == 4'h0 && vreg[x] == vreg[y]) prog_ctr = prog_ctr + 12'd2;
			NIB_SNER: if (n == 4'h0 && vreg[x] != vreg[y]) prog_ctr = prog_ctr + 12'd2;
			NIB_LD:   vreg[x] = kk;
			NIB_ADD:  vreg[x] = vreg[x] + kk;
			NIB_ALU: begin
				// flag goes first, sub and shift results then see the new flag
				case (n)
					ALU_MOV: vreg[x] = vreg[y];
					ALU_OR:  vreg[x] = vreg[x] | vreg[y];
					ALU_AND: vreg[x] = vreg[x] & vreg[y];
					ALU_XOR: vreg[x] = vreg[x] ^ vreg[y];
					ALU_ADD: begin
						sum = {1'b0, vreg[x]} + {1'b0, vreg[y]};
						vreg[15] = {7'd0, sum[8]};
						vreg[x] = sum[7:0];
					end
					ALU_SUB: begin
						vreg[15] = {7'd0, vreg[x] > vreg[y]};
						vreg[x] = vreg[x] - vreg[y];
					end
					ALU_SHR: begin
						vreg[15] = {7'd0, vreg[x][0]};
						vreg[x] = vreg[x] >> 1;
					end
					ALU_SUBN: begin
						vreg[15] = {7'd0, vreg[y] > vreg[x]};
						vreg[x] = vreg[y] - vreg[x];
					end
					ALU_SHL: begin
						vreg[15] = {7'd0, vreg[x][7]};
						vreg[x] = vreg[x] << 1;
					end
					default: ;
				endcase
			end
			NIB_LDI: ireg = {4'd0, nnn};
			NIB_JPV: prog_ctr = nnn + {4'd0, vreg[0]};
			NIB_DRW: begin
				// wrapping xor sprite, flag on any pixel turned off
				px = vreg[x];
				py = vreg[y];
				vreg[15] = '0;
				hit = 1'b0;
				for (int r = 0; r < n; r++) begin
					spb = ram[ireg[11:0] + 12'(r)];
					sy = (py + r) % DEF_SCREEN_HEIGHT;
					for (int c = 0; c < 8; c++) begin
						sx = (px + c) % DEF_SCREEN_WIDTH;
						if (spb[7 - c]) begin
							if (screen[sy][63 - sx]) hit = 1'b1;
							screen[sy][63 - sx] = ~screen[sy][63 - sx];
						end
					end
				end
				if (hit) vreg[15] = 8'd1;
				disp = 1'b1;
			end
			NIB_KEY: begin
				down = vreg[x] < 8'd16 && key_held[vreg[x][3:0]];
				if (kk == KK_SKP && down) prog_ctr = prog_ctr + 12'd2;
				else if (kk == KK_SKNP && !down) prog_ctr = prog_ctr + 12'd2;
			end
			NIB_MISC: begin
				case (kk)
					KK_GDT: vreg[x] = 8'((delay_left / DEF_TICK_MS) & 'hFF);
					KK_WKEY: begin
						for (k = 0; k < 16; k++) if (key_held[k]) break;
						if (k < 16) vreg[x] = 8'(k);
						else begin
							prog_ctr = prog_ctr - 12'd2;
							wkey = 1'b1;
						end
					end
					KK_SDT:  delay_left = (vreg[x] * DEF_TICK_MS) & 'hFFF;
					KK_SST:  sound_left = (vreg[x] * DEF_TICK_MS) & 'hFFF;
					KK_ADDI: ireg = ireg + {8'd0, vreg[x]};
					KK_FONT: ireg = 16'(DEF_FONT_BASE + vreg[x] * GLYPH_BYTES);
					KK_BCD: begin
						ram[ireg[11:0]]         = vreg[x] / 100;
						ram[ireg[11:0] + 12'd1] = (vreg[x] / 10) % 10;
						ram[ireg[11:0] + 12'd2] = vreg[x] % 10;
					end
					KK_STR: for (int i = 0; i <= x; i++) ram[ireg[11:0] + 12'(i)] = vreg[i];
					KK_LDR: for (int i = 0; i <= x; i++) vreg[i] = ram[ireg[11:0] + 12'(i)];
					default: ;
				endcase
			end
			default: ;
		endcase
		// random byte lands after the rest of the instruction
		if (op[15:12] == NIB_RND) vreg[op[11:8]] = rnd & op[7:0];
	endtask

	task automatic predict_beat(output core_status_t s);
		logic [15:0] op;
		logic        wkey, disp;
		int          el;
		op = '0;
		wkey = 1'b0;
		disp = 1'b0;
		s.row_bits = '0;
		case (kind)
			KIND_LOAD: ram[address] = data_byte;
			KIND_EXEC: run_instruction(random_byte, op, wkey, disp);
			KIND_KEY:  key_held[key_index] = key_down;
			KIND_TIME: begin
				el = elapsed_ms;
				delay_left = delay_left > el ? delay_left - el : 0;
				sound_left = sound_left > el ? sound_left - el : 0;
			end
			KIND_ROW: if (row_select < DEF_SCREEN_HEIGHT) s.row_bits = screen[row_select];
			default: ;
		endcase
		s.opcode = op;
		s.pc = prog_ctr;
		s.index_addr = ireg;
		s.flag_value = vreg[15];
		s.waiting_key = wkey;
		s.sound_on = sound_left != 0;
		s.display_changed = disp;
	endtask

	// predict on input beats, compare on result beats
	always @(posedge clk or negedge arst_n) begin
		core_status_t s, e;
		if (!arst_n) begin
			clear_model();
			status_q.delete();
			mismatches <= 0;
		end else begin
			if (in_valid && in_ready) begin
				predict_beat(s);
				status_q.push_back(s);
			end
			if (out_valid && out_ready) begin
				if (status_q.size() == 0) begin
					if (mismatches < 10) $display("unexpected result beat, opcode %h pc %h",
						opcode, pc);
					mismatches <= mismatches + 1;
				end else begin
					e = status_q.pop_front();
					if (opcode !== e.opcode || pc !== e.pc || index_addr !== e.index_addr ||
						flag_value !== e.flag_value || waiting_key !== e.waiting_key ||
						sound_on !== e.sound_on || display_changed !== e.display_changed ||
						row_bits !== e.row_bits) begin
						if (mismatches < 10) begin
							$display("mismatch exp: op %h pc %h i %h vf %h w %b s %b d %b row %h",
								e.opcode, e.pc, e.index_addr, e.flag_value, e.waiting_key,
								e.sound_on, e.display_changed, e.row_bits);
							$display("         got: op %h pc %h i %h vf %h w %b s %b d %b row %h",
								opcode, pc, index_addr, flag_value, waiting_key,
								sound_on, display_changed, row_bits);
						end
						mismatches <= mismatches + 1;
					end
				end
			end
		end
	end

endmodule

FILE: dv/tb_chip8_instruction_core_unit.sv
// ----------------------------------------------------------------------------
// tb_chip8_instruction_core_unit
// Stimulus and verdict for the instruction core: writes short programs into
// RAM at the current program counter and runs them, mixed with key, time,
// row and unused-kind beats, under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_chip8_instruction_core_unit;
	import c8ic_pkg::*;

	localparam int HANG_LIMIT = 20000;
	localparam int ITEM_GOAL  = 1850;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  kind = '0;
	logic [11:0] address = '0;
	logic [7:0]  data_byte = '0;
	logic [3:0]  key_index = '0;
	logic        key_down = 1'b0;
	logic [15:0] elapsed_ms = '0;
	logic [7:0]  random_byte = '0;
	logic [4:0]  row_select = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] opcode;
	logic [11:0] pc;
	logic [15:0] index_addr;
	logic [7:0]  flag_value;
	logic        waiting_key;
	logic        sound_on;
	logic        display_changed;
	logic [63:0] row_bits;
	logic        end_of_run = 1'b0;
	int          fail_count;

	int          beats_sent = 0;
	int          beats_seen = 0;
	logic [11:0] last_pc = 12'(DEF_PROGRAM_START);
	bit          quiet_send = 0;
	bit          hold_req = 0;
	int          idle_cycles = 0;

	always #2 clk = ~clk;

	chip8_instruction_core_unit i_dut (.*);

	chip8_core_checker i_checker (.*);

	// sends one beat, field values beyond the fixed ones are random
	task automatic send_beat(input logic [2:0] k, input logic [11:0] a, input logic [7:0] d);
		int  gap;
		bit  took;
		gap = quiet_send ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		address <= a;
		data_byte <= d;
		key_index <= 4'($urandom);
		key_down <= 1'($urandom);
		elapsed_ms <= ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
		random_byte <= 8'($urandom);
		row_select <= 5'($urandom);
		do begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end while (!took);
		beats_sent++;
	endtask

	// lower valid and wait for every result, program counter is then known
	task automatic drain();
		in_valid <= 1'b0;
		wait (beats_seen == beats_sent);
		@(posedge clk);
	endtask

	// writes instructions at the program counter and runs them
	task automatic run_program(input logic [15:0] prog[$]);
		logic [11:0] at;
		drain();
		// the long hold-off starts with a full program still to send
		if (beats_sent >= 300) hold_req = 1;
		at = last_pc;
		foreach (prog[i]) begin
			send_beat(KIND_LOAD, at, prog[i][15:8]);
			send_beat(KIND_LOAD, at + 12'd1, prog[i][7:0]);
			at = at + 12'd2;
		end
		foreach (prog[i]) begin
			send_beat(KIND_EXEC, 12'($urandom), 8'($urandom));
			case ($urandom_range(0, 9))
				0: send_beat(KIND_KEY, 12'($urandom), 8'($urandom));
				1: send_beat(KIND_TIME, 12'($urandom), 8'($urandom));
				2: send_beat(KIND_ROW, 12'($urandom), 8'($urandom));
				3: send_beat(3'($urandom_range(5, 7)), 12'($urandom), 8'($urandom));
				default: ;
			endcase
		end
	endtask

	function automatic logic [15:0] pick_instruction();
		logic [7:0] misc_codes [11] = '{KK_GDT, KK_WKEY, KK_SDT, KK_SST, KK_ADDI,
			KK_FONT, KK_BCD, KK_STR, KK_LDR, 8'h00, 8'hFF};
		logic [3:0] alu_codes [11] = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD,
			ALU_SUB, ALU_SHR, ALU_SUBN, ALU_SHL, 4'h9, 4'hF};
		logic [15:0] w;
		w = 16'($urandom);
		case (w[15:12])
			NIB_SYS: case ($urandom_range(0, 3))
				0: w = OP_CLS;
				1: w = OP_RET;
				default: w[15:12] = NIB_SYS;
			endcase
			NIB_SER, NIB_SNER: if ($urandom_range(0, 3) != 0) w[3:0] = 4'h0;
			NIB_ALU:  if ($urandom_range(0, 7) != 0) w[3:0] = alu_codes[$urandom_range(0, 8)];
			NIB_KEY:  if ($urandom_range(0, 5) != 0) w[7:0] = $urandom_range(0, 1) ? KK_SKP : KK_SKNP;
			NIB_MISC: w[7:0] = misc_codes[$urandom_range(0, 10)];
			NIB_JP, NIB_CALL, NIB_JPV: w[11:0] = 12'($urandom_range(0, 4095));
			default: ;
		endcase
		// keep small register values common so compares and keys hit
		if ($urandom_range(0, 3) == 0) w = {NIB_LD, 4'($urandom), 8'($urandom_range(0, 17))};
		return w;
	endfunction

	// result side with random stalls and one long hold-off
	initial begin
		int  gap;
		bit  took;
		bit  held = 0;
		wait (arst_n);
		forever begin
			if (!held && hold_req) begin
				held = 1;
				out_ready <= 1'b0;
				repeat (600) @(posedge clk);
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do begin
				@(negedge clk);
				took = out_valid;
				if (took) last_pc = pc;
				@(posedge clk);
			end while (!took);
			beats_seen++;
		end
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= HANG_LIMIT) begin
			$display("[chip8_instruction_core_unit] ERROR");
			$finish;
		end
	end

	initial begin
		logic [15:0] prog[$];
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: carry, borrow, flag as operand, shifts, draw and bcd across the RAM end, blocks
		prog = '{16'h00E0, 16'h60FF, 16'h6101, 16'h8014, 16'h6FFF, 16'h8F15, 16'h6080,
			16'h800E, 16'h8F16, 16'hAFFE, 16'hD01F, 16'hF01E, 16'h6FC8, 16'hFF33,
			16'hFF55, 16'hFF65, 16'hF00A, 16'h60FF, 16'hF015, 16'hF018, 16'hC0FF,
			16'h2FFE, 16'h00EE};
		run_program(prog);
		send_beat(KIND_TIME, '0, '0);
		send_beat(KIND_ROW, '0, '0);
		send_beat(3'd7, '0, '0);

		// random short programs
		while (beats_sent < ITEM_GOAL) begin
			quiet_send = ($urandom_range(0, 4) == 0);
			prog.delete();
			repeat ($urandom_range(1, 6)) prog.push_back(pick_instruction());
			run_program(prog);
		end

		drain();
		end_of_run <= 1'b1;
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("[chip8_instruction_core_unit] OK");
		else
			$display("[chip8_instruction_core_unit] ERROR");
		$finish;
	end

endmodule
